FILE: hdl/eihp_pkg.sv
// ----------------------------------------------------------------------------
// eihp_pkg
// shared types and constants of the ethernet / ipv4 / l4 header parser
// ----------------------------------------------------------------------------
package eihp_pkg;

    localparam int COUNT_W         = 12;
    localparam int COUNT_MAX       = 4095;
    localparam int MIN_PARSE_BYTES = 54;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_ICMP     = 8'd1;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;

    localparam logic [4:0] TCP_HDR_BYTES  = 5'd20;
    localparam logic [4:0] UDP_HDR_BYTES  = 5'd8;
    localparam logic [4:0] ICMP_HDR_BYTES = 5'd8;

    typedef enum logic [2:0] {
        ST_PAYLOAD     = 3'd0,
        ST_NO_PAYLOAD  = 3'd1,
        ST_SHORT       = 3'd2,
        ST_NOT_IPV4    = 3'd3,
        ST_OTHER_PROTO = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        L4_NONE = 2'd0,
        L4_TCP  = 2'd1,
        L4_UDP  = 2'd2,
        L4_ICMP = 2'd3
    } l4_kind_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       end_of_frame;
    } in_item_t;

    // captured header fields of one frame, handed from front to back
    typedef struct packed {
        logic        short_frame;
        logic [47:0] dest_mac;
        logic [47:0] source_mac;
        logic [15:0] ether_type;
        logic [3:0]  header_words;
        logic [15:0] total_length;
        logic [7:0]  ttl;
        logic [7:0]  protocol;
        logic [31:0] source_ip;
        logic [31:0] dest_ip;
        logic [15:0] source_port;
        logic [15:0] dest_port;
    } hdr_rec_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [47:0] dest_mac;
        logic [47:0] source_mac;
        logic [15:0] ether_type;
        logic [31:0] dest_ip;
        logic [31:0] source_ip;
        logic [7:0]  time_to_live;
        logic [1:0]  l4_kind;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [15:0] payload_length;
    } out_item_t;

endpackage

FILE: hdl/eihp_stream_if.sv
// ----------------------------------------------------------------------------
// eihp_stream_if
// valid / ready channel carrying one payload per transaction
// ----------------------------------------------------------------------------
interface eihp_stream_if #(
    parameter type payload_t = logic
) ();

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );

endinterface

FILE: hdl/eihp_front.sv
// ----------------------------------------------------------------------------
// eihp_front
// byte counter and header field capture; pushes one record per frame
// ----------------------------------------------------------------------------
module eihp_front
    import eihp_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 2048
) (
    input  logic          clk,
    input  logic          rst_n,
    eihp_stream_if.sink   frame_in,
    eihp_stream_if.source hdr_out
);

    localparam int LIMIT_INT = (MAX_FRAME_BYTES > COUNT_MAX) ? COUNT_MAX : MAX_FRAME_BYTES;
    localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(LIMIT_INT);

    logic [COUNT_W-1:0] count_reg, count_next, count_after;
    hdr_rec_t           cur_reg, cur_next, cap;
    logic [7:0]         b;
    logic [3:0]         hw_new;
    logic [COUNT_W-1:0] l4_pos, l4_off;
    logic               below_limit;
    logic               accept;

    assign b           = frame_in.payload.frame_byte;
    assign below_limit = count_reg < COUNT_LIMIT;
    assign count_after = below_limit ? count_reg + 1'b1 : count_reg;
    assign hw_new      = (count_reg == COUNT_W'(14)) ? b[3:0] : cur_reg.header_words;
    assign l4_pos      = COUNT_W'(14) + COUNT_W'({hw_new, 2'b00});
    assign l4_off      = count_reg - l4_pos;

    // each byte lands in its final lane, so a field cut short by the end of
    // the frame keeps zeros in the lanes it never reached
    always_comb
    begin
        cap = cur_reg;
        if (below_limit)
        begin
            case (count_reg) inside
                0:       cap.dest_mac[47:40]     = b;
                1:       cap.dest_mac[39:32]     = b;
                2:       cap.dest_mac[31:24]     = b;
                3:       cap.dest_mac[23:16]     = b;
                4:       cap.dest_mac[15:8]      = b;
                5:       cap.dest_mac[7:0]       = b;
                6:       cap.source_mac[47:40]   = b;
                7:       cap.source_mac[39:32]   = b;
                8:       cap.source_mac[31:24]   = b;
                9:       cap.source_mac[23:16]   = b;
                10:      cap.source_mac[15:8]    = b;
                11:      cap.source_mac[7:0]     = b;
                12:      cap.ether_type[15:8]    = b;
                13:      cap.ether_type[7:0]     = b;
                14:      cap.header_words        = b[3:0];
                16:      cap.total_length[15:8]  = b;
                17:      cap.total_length[7:0]   = b;
                22:      cap.ttl                 = b;
                23:      cap.protocol            = b;
                26:      cap.source_ip[31:24]    = b;
                27:      cap.source_ip[23:16]    = b;
                28:      cap.source_ip[15:8]     = b;
                29:      cap.source_ip[7:0]      = b;
                30:      cap.dest_ip[31:24]      = b;
                31:      cap.dest_ip[23:16]      = b;
                32:      cap.dest_ip[15:8]       = b;
                33:      cap.dest_ip[7:0]        = b;
                default: ;
            endcase
            if (count_reg >= l4_pos && l4_off < COUNT_W'(4))
            begin
                case (l4_off[1:0])
                    2'd0:    cap.source_port[15:8] = b;
                    2'd1:    cap.source_port[7:0]  = b;
                    2'd2:    cap.dest_port[15:8]   = b;
                    default: cap.dest_port[7:0]    = b;
                endcase
            end
        end
        cap.short_frame = count_after < COUNT_W'(MIN_PARSE_BYTES);
    end

    assign frame_in.ready  = hdr_out.ready;
    assign hdr_out.valid   = frame_in.valid && frame_in.payload.end_of_frame;
    assign hdr_out.payload = cap;
    assign accept          = frame_in.valid && frame_in.ready;

    always_comb
    begin
        count_next = count_reg;
        cur_next   = cur_reg;
        if (accept)
        begin
            if (frame_in.payload.end_of_frame)
            begin
                count_next = '0;
                cur_next   = '0;
            end
            else
            begin
                count_next = count_after;
                cur_next   = cap;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            cur_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            cur_reg   <= cur_next;
        end
    end

endmodule

FILE: hdl/eihp_queue.sv
// ----------------------------------------------------------------------------
// eihp_queue
// short record queue between capture front and summary back
// ----------------------------------------------------------------------------
module eihp_queue
    import eihp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    eihp_stream_if.sink   push,
    eihp_stream_if.source pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    hdr_rec_t         entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   fill_reg, fill_next;
    logic             do_push, do_pop;

    assign push.ready  = fill_reg < (PTR_W + 1)'(QUEUE_DEPTH);
    assign pop.valid   = fill_reg != '0;
    assign pop.payload = entry_reg[rd_ptr_reg];
    assign do_push     = push.valid && push.ready;
    assign do_pop      = pop.valid && pop.ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push.payload;
        end
    end

endmodule

FILE: hdl/eihp_back.sv
// ----------------------------------------------------------------------------
// eihp_back
// classifies a captured header and registers the frame summary
// ----------------------------------------------------------------------------
module eihp_back
    import eihp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    eihp_stream_if.sink   hdr_in,
    eihp_stream_if.source summary_out
);

    hdr_rec_t    rec;
    out_item_t   sum;
    out_item_t   out_reg;
    logic        out_valid_reg, out_valid_next;
    l4_kind_t    kind;
    logic [4:0]  l4_bytes;
    logic [16:0] diff;
    logic [15:0] plen;
    logic        take;

    assign rec = hdr_in.payload;

    always_comb
    begin
        case (rec.protocol)
            PROTO_TCP:
            begin
                kind     = L4_TCP;
                l4_bytes = TCP_HDR_BYTES;
            end
            PROTO_UDP:
            begin
                kind     = L4_UDP;
                l4_bytes = UDP_HDR_BYTES;
            end
            PROTO_ICMP:
            begin
                kind     = L4_ICMP;
                l4_bytes = ICMP_HDR_BYTES;
            end
            default:
            begin
                kind     = L4_NONE;
                l4_bytes = '0;
            end
        endcase
    end

    // negative result shows as the borrow bit, clamped to zero
    assign diff = {1'b0, rec.total_length} - {11'b0, rec.header_words, 2'b00}
                  - {12'b0, l4_bytes};
    assign plen = diff[16] ? '0 : diff[15:0];

    always_comb
    begin
        sum                = '0;
        sum.dest_mac       = rec.dest_mac;
        sum.source_mac     = rec.source_mac;
        sum.ether_type     = rec.ether_type;
        sum.dest_ip        = rec.dest_ip;
        sum.source_ip      = rec.source_ip;
        sum.time_to_live   = rec.ttl;
        if (rec.short_frame)
        begin
            sum.status = ST_SHORT;
        end
        else if (rec.ether_type != ETHERTYPE_IPV4)
        begin
            sum.status = ST_NOT_IPV4;
        end
        else if (kind == L4_NONE)
        begin
            sum.status = ST_OTHER_PROTO;
        end
        else
        begin
            sum.status         = (plen != '0) ? ST_PAYLOAD : ST_NO_PAYLOAD;
            sum.l4_kind        = kind;
            sum.payload_length = plen;
            if (kind == L4_TCP || kind == L4_UDP)
            begin
                sum.source_port = rec.source_port;
                sum.dest_port   = rec.dest_port;
            end
        end
    end

    assign hdr_in.ready        = !out_valid_reg || summary_out.ready;
    assign take                = hdr_in.valid && hdr_in.ready;
    assign summary_out.valid   = out_valid_reg;
    assign summary_out.payload = out_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take)
        begin
            out_valid_next = 1'b1;
        end
        else if (summary_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_reg <= sum;
        end
    end

endmodule

FILE: hdl/ethernet_ipv4_l4_header_parser.sv
// ----------------------------------------------------------------------------
// ethernet_ipv4_l4_header_parser
// streaming ethernet / ipv4 / tcp-udp header parser with one summary per frame
// ----------------------------------------------------------------------------
// frame bytes enter on frame_in in wire order, one per transaction, and the
// block takes one byte every cycle while its header queue has room. the byte
// flagged end_of_frame closes the frame: its captured header goes into a
// two-entry queue, from which the back pops it and offers the summary on
// summary_out, registered. the input side only stalls when two finished
// headers are already waiting in the queue behind a stalled summary_out.
// bytes past MAX_FRAME_BYTES (at most 4095) are dropped but the frame still
// ends with its end_of_frame byte. status: payload found, no payload, frame
// under 54 bytes, not ipv4, or ipv4 with a protocol other than tcp, udp or
// icmp; in the last three cases kind, ports and payload length read zero.
// fields whose bytes never arrived read zero.
// ----------------------------------------------------------------------------
module ethernet_ipv4_l4_header_parser
    import eihp_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 2048
) (
    input  logic          clk,
    input  logic          rst_n,
    eihp_stream_if.sink   frame_in,
    eihp_stream_if.source summary_out
);

    // front -> queue and queue -> back channels
    eihp_stream_if #(.payload_t(hdr_rec_t)) front_ch ();
    eihp_stream_if #(.payload_t(hdr_rec_t)) back_ch ();

    // byte capture, one byte per cycle while the queue has room
    eihp_front #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .frame_in (frame_in),
        .hdr_out  (front_ch.source)
    );

    // decouples capture from a stalled summary consumer
    eihp_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (front_ch.sink),
        .pop   (back_ch.source)
    );

    // classification and summary output register
    eihp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .hdr_in      (back_ch.sink),
        .summary_out (summary_out)
    );

    // a closing byte always lands in the queue in the same cycle
    a_eof_pushes: assert property (@(posedge clk) disable iff (!rst_n)
        frame_in.valid && frame_in.ready && frame_in.payload.end_of_frame
        |-> front_ch.valid && front_ch.ready)
        else $error("end of frame accepted without queue push");

    // a record taken by the back shows up as a summary next cycle
    a_pop_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        back_ch.valid && back_ch.ready |=> summary_out.valid)
        else $error("queue pop did not produce a summary");

    // rejected frames carry no l4 information
    a_short_clean: assert property (@(posedge clk) disable iff (!rst_n)
        summary_out.valid && (summary_out.payload.status == ST_SHORT
            || summary_out.payload.status == ST_NOT_IPV4
            || summary_out.payload.status == ST_OTHER_PROTO)
        |-> summary_out.payload.l4_kind == L4_NONE
            && summary_out.payload.payload_length == '0)
        else $error("rejected frame with l4 fields");

    // payload status agrees with the length
    a_payload_len: assert property (@(posedge clk) disable iff (!rst_n)
        summary_out.valid && summary_out.payload.status == ST_PAYLOAD
        |-> summary_out.payload.payload_length != '0)
        else $error("payload status with zero length");

endmodule
